FILE: rtl/fsps_pkg.sv
// shared constants and types for the five-point stencil stream
`timescale 1ns / 1ps

package fsps_pkg;

    // default sizes
    localparam int DEF_MAX_LINE    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration register widths and reset values
    localparam int IL_W       = 10;
    localparam int LC_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [IL_W-1:0] IL_RESET = 10'd1022;
    localparam logic [LC_W-1:0] LC_RESET = 16'd1022;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'b1;

    // Q0.16 weights: 0.6 for the centre, 0.1 for each neighbor
    localparam int             WEIGHT_W  = 16;
    localparam int             FRAC_BITS = 16;
    localparam logic [WEIGHT_W-1:0] W_CENTRE = 16'd39322;
    localparam logic [WEIGHT_W-1:0] W_NEIGH  = 16'd6554;

    // per-item control that rides along with the taps
    typedef struct packed {
        logic emit;
        logic last;
    } stage_tag_t;

endpackage

FILE: rtl/fsps_line_buf.sv
// two line memories with the left-tap register and older-line forwarding
`timescale 1ns / 1ps

module fsps_line_buf #(
    parameter int MAX_LINE    = fsps_pkg::DEF_MAX_LINE,
    parameter int SAMPLE_BITS = fsps_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc_en,
    input  logic [$clog2(MAX_LINE)-1:0]  acc_addr,
    input  logic [SAMPLE_BITS-1:0]       acc_sample,
    input  logic                         wb_en,
    output logic [SAMPLE_BITS-1:0]       up,
    output logic [SAMPLE_BITS-1:0]       left,
    output logic [SAMPLE_BITS-1:0]       centre,
    output logic [SAMPLE_BITS-1:0]       right
);
    import fsps_pkg::*;

    localparam int CW = $clog2(MAX_LINE);

    logic [SAMPLE_BITS-1:0] older_mem [MAX_LINE];
    logic [SAMPLE_BITS-1:0] newer_mem [MAX_LINE];

    logic [SAMPLE_BITS-1:0] centre_reg;
    logic [SAMPLE_BITS-1:0] right_reg;
    logic [SAMPLE_BITS-1:0] up_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] fwd_val_reg;
    logic [CW-1:0]          addr_reg;
    logic                   fwd_reg;
    logic                   fwd_next;
    logic [CW-1:0]          right_addr;

    // right tap address, kept inside the array at the far end
    assign right_addr = (acc_addr == CW'(MAX_LINE - 1)) ? '0 : acc_addr + CW'(1);

    // newer line: read centre and right, then overwrite with the new sample
    always_ff @(posedge clk)
    begin
        if (acc_en)
        begin
            newer_mem[acc_addr] <= acc_sample;
            centre_reg          <= newer_mem[acc_addr];
            right_reg           <= newer_mem[right_addr];
        end
    end

    // older line: read up at accept, write back the centre as the item leaves the read stage
    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            older_mem[addr_reg] <= centre_reg;
        end
        if (acc_en)
        begin
            up_reg      <= older_mem[acc_addr];
            addr_reg    <= acc_addr;
            fwd_val_reg <= centre_reg;
        end
    end

    // same column written back in the cycle it is read again
    assign fwd_next = wb_en && (addr_reg == acc_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            if (acc_en)
            begin
                fwd_reg <= fwd_next;
            end
            // left tap is the centre of the item before
            if (wb_en)
            begin
                left_reg <= centre_reg;
            end
        end
    end

    assign up     = fwd_reg ? fwd_val_reg : up_reg;
    assign left   = left_reg;
    assign centre = centre_reg;
    assign right  = right_reg;

endmodule

FILE: rtl/fsps_weigh.sv
// weighting pipeline: products, round and saturate, output register
`timescale 1ns / 1ps

module fsps_weigh #(
    parameter int SAMPLE_BITS = fsps_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  fsps_pkg::stage_tag_t    in_tag,
    input  logic [SAMPLE_BITS-1:0]  up,
    input  logic [SAMPLE_BITS-1:0]  left,
    input  logic [SAMPLE_BITS-1:0]  centre,
    input  logic [SAMPLE_BITS-1:0]  right,
    input  logic [SAMPLE_BITS-1:0]  down,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_BITS-1:0]  value,
    output logic                    last
);
    import fsps_pkg::*;

    localparam int AW    = SAMPLE_BITS + 17;
    localparam int SUM_W = SAMPLE_BITS + 2;

    logic                   s2_v_reg;
    logic                   s2_last_reg;
    logic [AW-1:0]          pc_reg;
    logic [AW-1:0]          pn_reg;
    logic                   out_v_reg;
    logic [SAMPLE_BITS-1:0] value_reg;
    logic                   last_reg;

    logic                   en_out;
    logic [SUM_W-1:0]       sum4;
    logic [AW-1:0]          pc_next;
    logic [AW-1:0]          pn_next;
    logic [AW-1:0]          acc_rnd;
    logic [SAMPLE_BITS:0]   rnd;
    logic [SAMPLE_BITS-1:0] value_next;

    // stage enables, each stage moves when the one after has room
    assign en_out = !out_v_reg || out_ready;
    assign take   = !s2_v_reg || en_out;

    // neighbor sum and the two constant products
    assign sum4    = SUM_W'(up) + SUM_W'(left) + SUM_W'(right) + SUM_W'(down);
    assign pc_next = AW'(centre) * AW'(W_CENTRE);
    assign pn_next = AW'(sum4) * AW'(W_NEIGH);

    // round to nearest, ties up, then clamp at full scale
    assign acc_rnd    = pc_reg + pn_reg + AW'(2 ** (FRAC_BITS - 1));
    assign rnd        = acc_rnd[FRAC_BITS +: SAMPLE_BITS + 1];
    assign value_next = rnd[SAMPLE_BITS] ? '1 : rnd[SAMPLE_BITS-1:0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s2_v_reg <= in_valid && in_tag.emit;
            end
            if (en_out)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pc_reg      <= pc_next;
            pn_reg      <= pn_next;
            s2_last_reg <= in_tag.last;
        end
        if (en_out && s2_v_reg)
        begin
            value_reg <= value_next;
            last_reg  <= s2_last_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/five_point_stencil_stream_top.sv
// Five-point stencil over a padded grid stream, with two line memories.
// Usage:
//   Samples enter on the s_ channel in storage order, halo included: lines of
//   interior_len+2 samples, line_count+2 lines. s_tuser marks the first sample
//   of a frame and restarts the line and column counters.
//   Each interior sample yields 0.6*centre + 0.1*(up+down+left+right) in
//   unsigned Q8.8, rounded to nearest and saturated; the item is produced
//   when the sample one line below arrives. m_tlast marks the final result.
//   Config writes (cfg_we, cfg_index, cfg_data) go in while the block idles.
// Throughput and pipeline:
//   One item per cycle while m_tready does not stall the output. A result
//   passes the read stage, the product registers and the output register:
//   memory read, multiply, round and saturate. The line memories take one
//   read-modify-write per item, so there is no other limit on rate.
// Reset and stall:
//   Reset clears counters, valid bits and the left tap; config returns to
//   1022 by 1022. Line memories come up unknown and need no clearing pass.
//   With m_tready low the output register holds its item; input is still
//   taken until the product and read stages fill, then s_tready drops.
`timescale 1ns / 1ps

module five_point_stencil_stream_top #(
    parameter int MAX_LINE    = fsps_pkg::DEF_MAX_LINE,
    parameter int SAMPLE_BITS = fsps_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [fsps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fsps_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // bits: sample, then zero fill
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // bit 0: frame_start
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // bits: value, then zero fill
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
    output logic                                   m_tlast
);
    import fsps_pkg::*;

    localparam int DW      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CW      = $clog2(MAX_LINE);
    localparam int EW      = (CW > IL_W) ? CW : IL_W;
    localparam int EFF_MAX = MAX_LINE - 2;

    logic [IL_W-1:0]        interior_len_reg;
    logic [LC_W-1:0]        line_count_reg;
    logic [CW-1:0]          pos_reg;
    logic [CW-1:0]          pos_next;
    logic [LC_W-1:0]        line_reg;
    logic [LC_W-1:0]        line_next;
    logic                   s1_v_reg;
    logic                   s1_v_next;
    stage_tag_t             s1_tag_reg;
    stage_tag_t             tag_next;
    logic [SAMPLE_BITS-1:0] s1_down_reg;

    logic                   accept;
    logic                   take;
    logic                   wb_en;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CW-1:0]          col;
    logic [EW-1:0]          col_ext;
    logic [LC_W-1:0]        line;
    logic [EW-1:0]          eff;
    logic [LC_W:0]          lc_plus1;
    logic [SAMPLE_BITS-1:0] up;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] centre;
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] value;

    // handshake
    assign s_tready = !s1_v_reg || take;
    assign accept   = s_tvalid && s_tready;
    assign wb_en    = s1_v_reg && take;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interior_len_reg <= IL_RESET;
            line_count_reg   <= LC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTERIOR_LEN: interior_len_reg <= cfg_data[IL_W-1:0];
                CFG_LINE_COUNT:   line_count_reg   <= cfg_data[LC_W-1:0];
            endcase
        end
    end

    // position of the accepted sample, frame start restarts it
    assign col      = s_tuser[0] ? '0 : pos_reg;
    assign line     = s_tuser[0] ? '0 : line_reg;
    assign col_ext  = EW'(col);
    assign eff      = (EW'(interior_len_reg) > EW'(EFF_MAX)) ? EW'(EFF_MAX)
                                                             : EW'(interior_len_reg);
    assign lc_plus1 = {1'b0, line_count_reg} + (LC_W + 1)'(1);

    // result and last-result flags, last only on an item that forms a result
    always_comb
    begin
        tag_next.emit = (line >= LC_W'(2)) && ({1'b0, line} <= lc_plus1)
                        && (col != '0) && (col_ext <= eff);
        tag_next.last = (line >= LC_W'(2)) && (col != '0)
                        && ({1'b0, line} == lc_plus1) && (col_ext == eff);
    end

    // counter advance, wrap after the right halo column
    always_comb
    begin
        if (col_ext > eff)
        begin
            pos_next  = '0;
            line_next = line + LC_W'(1);
        end
        else
        begin
            pos_next  = col + CW'(1);
            line_next = line;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_v_next = 1'b1;
        end
        else if (take)
        begin
            s1_v_next = 1'b0;
        end
        else
        begin
            s1_v_next = s1_v_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            line_reg   <= '0;
            s1_v_reg   <= 1'b0;
            s1_tag_reg <= '0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            if (accept)
            begin
                pos_reg    <= pos_next;
                line_reg   <= line_next;
                s1_tag_reg <= tag_next;
            end
        end
    end

    // down tap travels beside the memory reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_down_reg <= sample;
        end
    end

    fsps_line_buf #(
        .MAX_LINE    (MAX_LINE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_en     (accept),
        .acc_addr   (col),
        .acc_sample (sample),
        .wb_en      (wb_en),
        .up         (up),
        .left       (left),
        .centre     (centre),
        .right      (right)
    );

    fsps_weigh #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_weigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .in_tag    (s1_tag_reg),
        .up        (up),
        .left      (left),
        .centre    (centre),
        .right     (right),
        .down      (s1_down_reg),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .value     (value),
        .last      (m_tlast)
    );

    assign m_tdata = DW'(value);

    // an item enters only while the read stage drains, so its write-back lands
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_v_reg |-> take)
        else $error("item accepted over an occupied read stage");

    // a waiting result does not block input while the read stage is empty
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && !s1_v_reg |-> s_tready)
        else $error("input blocked behind a stalled result");

    // the last flag only rides on an item that forms a result
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && s1_tag_reg.last |-> s1_tag_reg.emit)
        else $error("last flag on an item without a result");

endmodule
